### sv/light_state_to_rgb_assert.svh
// assertion macros used by the light state to rgb back end
`ifndef LIGHT_STATE_TO_RGB_ASSERT_SVH
`define LIGHT_STATE_TO_RGB_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lsr_pkg.sv
// shared types, codes, constants and constant dividers for the light state to rgb block
package lsr_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int PCT_W    = 7;
    localparam int TP_W     = 13;

    localparam logic [OPCODE_W-1:0] OP_POWER      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_BRIGHTNESS = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HUE        = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SATURATION = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TEMPERATURE = 3'd4;

    localparam logic [VALUE_W-1:0] T_MIN   = 16'd2000;
    localparam logic [VALUE_W-1:0] T_MAX   = 16'd6500;
    localparam logic [TP_W-1:0]    TP_MAX  = 13'd4500;
    localparam logic [PCT_W-1:0]   PCT_MAX = 7'd100;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // one classified event: full light state after the update
    typedef struct packed {
        logic                power_on;
        logic [PCT_W-1:0]    brightness;
        logic [VALUE_W-1:0]  hue;
        logic [PCT_W-1:0]    saturation;
        logic                temp_mode;
        logic [TP_W-1:0]     temp_p;
    } lsr_job_t;

    // x / 100 for x <= 25500
    function automatic logic [COLOR_W-1:0] div100(input logic [14:0] x);
        logic [30:0] prod;
        prod = 31'(x) * 31'd41944;
        return prod[29:22];
    endfunction

    // x / 60 for x <= 15300
    function automatic logic [COLOR_W-1:0] div60(input logic [13:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'd17477;
        return prod[27:20];
    endfunction

    // x / 4500 for x <= 787500
    function automatic logic [COLOR_W-1:0] div4500(input logic [19:0] x);
        logic [39:0] prod;
        prod = 40'(x) * 40'd954438;
        return prod[39:32];
    endfunction

    // x / 360 for any 16-bit x
    function automatic logic [COLOR_W-1:0] div360(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'd46604;
        return prod[31:24];
    endfunction

endpackage

### sv/lsr_front.sv
// front end: takes set events, keeps the light state, emits one job per event
module lsr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [lsr_pkg::OPCODE_W-1:0] opcode,
    input  logic [lsr_pkg::VALUE_W-1:0]  set_value,
    input  logic                         q_full,
    output logic                         q_push,
    output lsr_pkg::lsr_job_t            job
);
    import lsr_pkg::*;

    logic               power_reg, power_next;
    logic [PCT_W-1:0]   bri_reg, bri_next;
    logic [VALUE_W-1:0] hue_reg, hue_next;
    logic [PCT_W-1:0]   sat_reg, sat_next;
    logic               mode_reg, mode_next;
    logic [TP_W-1:0]    tp_reg, tp_next;
    logic [PCT_W-1:0]   pct_clamped;
    logic [VALUE_W-1:0] tp_wide;

    assign q_push = push && !q_full;

    assign pct_clamped = (set_value > VALUE_W'(PCT_MAX)) ? PCT_MAX : set_value[PCT_W-1:0];
    assign tp_wide = (set_value < T_MIN) ? '0 :
                     (set_value > T_MAX) ? VALUE_W'(TP_MAX) : (set_value - T_MIN);

    always_comb
    begin
        power_next = power_reg;
        bri_next   = bri_reg;
        hue_next   = hue_reg;
        sat_next   = sat_reg;
        mode_next  = mode_reg;
        tp_next    = tp_reg;
        case (opcode)
            OP_POWER:
            begin
                power_next = set_value[0];
            end
            OP_BRIGHTNESS:
            begin
                // zero brightness is ignored
                if (set_value != '0)
                begin
                    bri_next = pct_clamped;
                end
            end
            OP_HUE:
            begin
                hue_next  = set_value;
                mode_next = 1'b0;
            end
            OP_SATURATION:
            begin
                sat_next  = pct_clamped;
                mode_next = 1'b0;
            end
            OP_TEMPERATURE:
            begin
                tp_next   = tp_wide[TP_W-1:0];
                mode_next = 1'b1;
            end
            default:
            begin
                power_next = power_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= 1'b0;
            bri_reg   <= '0;
            hue_reg   <= '0;
            sat_reg   <= '0;
            mode_reg  <= 1'b0;
            tp_reg    <= '0;
        end
        else if (q_push)
        begin
            power_reg <= power_next;
            bri_reg   <= bri_next;
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            mode_reg  <= mode_next;
            tp_reg    <= tp_next;
        end
    end

    assign job.power_on   = power_next;
    assign job.brightness = bri_next;
    assign job.hue        = hue_next;
    assign job.saturation = sat_next;
    assign job.temp_mode  = mode_next;
    assign job.temp_p     = tp_next;

endmodule

### sv/lsr_queue.sv
// short job queue between front and back
module lsr_queue #(
    parameter int DEPTH = lsr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  lsr_pkg::lsr_job_t job_in,
    output logic              full,
    input  logic              pop_en,
    output lsr_pkg::lsr_job_t job_out,
    output logic              empty
);
    import lsr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    lsr_job_t           slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_en && !(pop_en && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_en && pop_en && !empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_en && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### sv/lsr_back.sv
// back end: sequenced hsv / color temperature conversion and result register
module lsr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  lsr_pkg::lsr_job_t           job_in,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [lsr_pkg::COLOR_W-1:0] red,
    output logic [lsr_pkg::COLOR_W-1:0] green,
    output logic [lsr_pkg::COLOR_W-1:0] blue
);
    import lsr_pkg::*;
    `include "light_state_to_rgb_assert.svh"

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_H1   = 4'd1;
    localparam logic [3:0] ST_H2   = 4'd2;
    localparam logic [3:0] ST_H3   = 4'd3;
    localparam logic [3:0] ST_H4   = 4'd4;
    localparam logic [3:0] ST_H5   = 4'd5;
    localparam logic [3:0] ST_H6   = 4'd6;
    localparam logic [3:0] ST_H7   = 4'd7;
    localparam logic [3:0] ST_T1   = 4'd8;
    localparam logic [3:0] ST_T2   = 4'd9;
    localparam logic [3:0] ST_T3   = 4'd10;
    localparam logic [3:0] ST_T4   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    // sextant of the hue: which channels get chroma and the ramp value
    localparam logic [2:0] SX_RED_UP   = 3'd0;
    localparam logic [2:0] SX_GREEN_DN = 3'd1;
    localparam logic [2:0] SX_GREEN_UP = 3'd2;
    localparam logic [2:0] SX_BLUE_DN  = 3'd3;
    localparam logic [2:0] SX_BLUE_UP  = 3'd4;
    localparam logic [2:0] SX_RED_DN   = 3'd5;

    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_reg [3];
    logic [COLOR_W-1:0] res_reg [3];

    lsr_job_t           job_reg;
    logic [COLOR_W-1:0] q360_reg;
    logic [14:0]        vnum_reg;
    logic [COLOR_W-1:0] v_reg;
    logic [8:0]         h_reg;
    logic [5:0]         d_reg;
    logic [2:0]         sext_reg;
    logic [14:0]        cnum_reg;
    logic [COLOR_W-1:0] c_reg;
    logic [13:0]        xnum_reg;
    logic [COLOR_W-1:0] x_reg;
    logic [COLOR_W-1:0] m_reg;
    logic [19:0]        num_reg [3];
    logic [COLOR_W-1:0] tc_reg [3];
    logic [14:0]        tb_reg [3];

    logic               black_in, black_job, load_out;
    logic [15:0]        hue_rem;
    logic [6:0]         hm;
    logic [6:0]         d_wide;

    assign black_in  = !job_in.power_on || (job_in.brightness == '0);
    assign black_job = !job_reg.power_on || (job_reg.brightness == '0);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || pop);

    assign hue_rem = job_reg.hue - ({8'd0, q360_reg} * 16'd360);
    assign hm      = (h_reg >= 9'd240) ? 7'(h_reg - 9'd240) :
                     (h_reg >= 9'd120) ? 7'(h_reg - 9'd120) : h_reg[6:0];
    assign d_wide  = (hm > 7'd60) ? (hm - 7'd60) : (7'd60 - hm);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = black_in ? ST_OUT : (job_in.temp_mode ? ST_T1 : ST_H1);
                end
            end
            ST_H1: state_next = ST_H2;
            ST_H2: state_next = ST_H3;
            ST_H3: state_next = ST_H4;
            ST_H4: state_next = ST_H5;
            ST_H5: state_next = ST_H6;
            ST_H6: state_next = ST_H7;
            ST_H7: state_next = ST_OUT;
            ST_T1: state_next = ST_T2;
            ST_T2: state_next = ST_T3;
            ST_T3: state_next = ST_T4;
            ST_T4: state_next = ST_OUT;
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath for the hsv and temperature steps
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= job_in;
                    if (black_in)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                    end
                end
            end
            ST_H1:
            begin
                q360_reg <= div360(job_reg.hue);
                vnum_reg <= 15'(job_reg.brightness) * 15'd255;
            end
            ST_H2:
            begin
                h_reg <= hue_rem[8:0];
                v_reg <= div100(vnum_reg);
            end
            ST_H3:
            begin
                d_reg    <= d_wide[5:0];
                sext_reg <= (h_reg < 9'd60)  ? SX_RED_UP   :
                            (h_reg < 9'd120) ? SX_GREEN_DN :
                            (h_reg < 9'd180) ? SX_GREEN_UP :
                            (h_reg < 9'd240) ? SX_BLUE_DN  :
                            (h_reg < 9'd300) ? SX_BLUE_UP  : SX_RED_DN;
                cnum_reg <= 15'(v_reg) * 15'(job_reg.saturation);
            end
            ST_H4:
            begin
                c_reg <= div100(cnum_reg);
            end
            ST_H5:
            begin
                xnum_reg <= 14'(c_reg) * 14'(6'd60 - d_reg);
                m_reg    <= v_reg - c_reg;
            end
            ST_H6:
            begin
                x_reg <= div60(xnum_reg);
            end
            ST_H7:
            begin
                case (sext_reg)
                    SX_RED_UP:
                    begin
                        res_reg[0] <= c_reg + m_reg;
                        res_reg[1] <= x_reg + m_reg;
                        res_reg[2] <= m_reg;
                    end
                    SX_GREEN_DN:
                    begin
                        res_reg[0] <= x_reg + m_reg;
                        res_reg[1] <= c_reg + m_reg;
                        res_reg[2] <= m_reg;
                    end
                    SX_GREEN_UP:
                    begin
                        res_reg[0] <= m_reg;
                        res_reg[1] <= c_reg + m_reg;
                        res_reg[2] <= x_reg + m_reg;
                    end
                    SX_BLUE_DN:
                    begin
                        res_reg[0] <= m_reg;
                        res_reg[1] <= x_reg + m_reg;
                        res_reg[2] <= c_reg + m_reg;
                    end
                    SX_BLUE_UP:
                    begin
                        res_reg[0] <= x_reg + m_reg;
                        res_reg[1] <= m_reg;
                        res_reg[2] <= c_reg + m_reg;
                    end
                    default:
                    begin
                        res_reg[0] <= c_reg + m_reg;
                        res_reg[1] <= m_reg;
                        res_reg[2] <= x_reg + m_reg;
                    end
                endcase
            end
            ST_T1:
            begin
                // warm to cool span per channel: -75, +40, +175
                num_reg[0] <= 20'(job_reg.temp_p) * 20'd75;
                num_reg[1] <= 20'(job_reg.temp_p) * 20'd40;
                num_reg[2] <= 20'(job_reg.temp_p) * 20'd175;
            end
            ST_T2:
            begin
                tc_reg[0] <= 8'd255 - div4500(num_reg[0]);
                tc_reg[1] <= 8'd180 + div4500(num_reg[1]);
                tc_reg[2] <= 8'd80 + div4500(num_reg[2]);
            end
            ST_T3:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tb_reg[i] <= 15'(tc_reg[i]) * 15'(job_reg.brightness);
                end
            end
            ST_T4:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= div100(tb_reg[i]);
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg[0] <= res_reg[0];
            out_reg[1] <= res_reg[1];
            out_reg[2] <= res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty = !out_valid_reg;
    assign red   = out_reg[0];
    assign green = out_reg[1];
    assign blue  = out_reg[2];

    `LSR_ASSERT_IMP(a_pop_only_idle, q_pop, state_reg == ST_IDLE, "job taken outside idle")
    `LSR_ASSERT_IMP(a_chroma_le_value, state_reg == ST_H5, c_reg <= v_reg, "chroma above value")
    `LSR_ASSERT_IMP(a_temp_span, state_reg == ST_T1, job_reg.temp_p <= TP_MAX,
        "temperature offset out of range")
    `LSR_ASSERT_NXT(a_black_out, load_out && black_job,
        !empty && red == '0 && green == '0 && blue == '0, "dark light gave nonzero drive")

endmodule

### sv/light_state_to_rgb.sv
// top level: light state register file with rgb drive output
//
//  channel   direction  handshake       word
//  event     in         push / full     opcode, set_value
//  drive     out        empty / pop     red, green, blue
//
// every accepted event word produces exactly one drive word, in order
// the back end steps dark events straight to output, temperature jobs
// through T1 to T4 and hsv jobs through H1 to H7, then waits for room
// the front end takes an event in any cycle the job queue has room
// reset (rst_n low, asynchronous) turns the light off, clears the light state
// and empties the queue and the output register
// a drive word waits in the output register while the queue keeps filling
module light_state_to_rgb #(
    parameter int QUEUE_DEPTH = lsr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [lsr_pkg::OPCODE_W-1:0] opcode,
    input  logic [lsr_pkg::VALUE_W-1:0]  set_value,
    output logic                         empty,
    input  logic                         pop,
    output logic [lsr_pkg::COLOR_W-1:0]  red,
    output logic [lsr_pkg::COLOR_W-1:0]  green,
    output logic [lsr_pkg::COLOR_W-1:0]  blue
);
    import lsr_pkg::*;

    // job path: front classifies and updates state, back converts
    lsr_job_t front_job;
    lsr_job_t back_job;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;

    // input side is full whenever the job queue is
    assign full = q_full;

    lsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .opcode    (opcode),
        .set_value (set_value),
        .q_full    (q_full),
        .q_push    (q_push),
        .job       (front_job)
    );

    lsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (q_push),
        .job_in  (front_job),
        .full    (q_full),
        .pop_en  (q_pop),
        .job_out (back_job),
        .empty   (q_empty)
    );

    // back end owns the output register and the result handshake
    lsr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .job_in  (back_job),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .red     (red),
        .green   (green),
        .blue    (blue)
    );

endmodule

### sim/light_state_to_rgb_tb.sv
// self-checking testbench for the light state to rgb block
`timescale 1ns / 100ps

module light_state_to_rgb_tb;
    import lsr_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 3000;   // cycles with no word moving on either side
    localparam int RANDOM_WORDS = 1730;
    localparam int DRAIN_CYCLES = 40;     // extra wait after everything is checked
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_AT      = 400;    // sent count that starts the long receiver hold-off
    localparam int HOLD_CYCLES  = 300;

    // one set event word and one drive word
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  val;
    } set_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_word_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                pop       = 1'b0;
    logic [OPCODE_W-1:0] opcode    = '0;
    logic [VALUE_W-1:0]  set_value = '0;
    logic                full;
    logic                empty;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;

    set_word_t event_words[$];     // set events still to be offered
    rgb_word_t drive_expected[$];  // drive words predicted but not yet seen

    int n_sent    = 0;
    int n_err     = 0;
    int stall_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // no idling on either side in this window of the run
    wire calm = (n_sent >= 700) && (n_sent < 1000);

    // shadow copy of the light state
    logic               lamp_on;
    logic [PCT_W-1:0]   lamp_bri;
    logic [VALUE_W-1:0] lamp_hue;
    logic [PCT_W-1:0]   lamp_sat;
    logic               lamp_temp_mode;
    logic [COLOR_W-1:0] lamp_tr;
    logic [COLOR_W-1:0] lamp_tg;
    logic [COLOR_W-1:0] lamp_tb;

    light_state_to_rgb u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .set_value (set_value),
        .empty     (empty),
        .pop       (pop),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        n_err++;
    endtask

    function automatic logic [PCT_W-1:0] clip_pct(input logic [VALUE_W-1:0] v);
        return (v > VALUE_W'(PCT_MAX)) ? PCT_MAX : PCT_W'(v);
    endfunction

    // rgb drive for the current shadow state
    function automatic rgb_word_t lamp_color();
        rgb_word_t   o;
        int unsigned h, v, c, hm, d, x, m, rr, gg, bb;
        rr = 0;
        gg = 0;
        bb = 0;
        if (lamp_on && lamp_bri != 0)
        begin
            if (lamp_temp_mode)
            begin
                rr = (lamp_tr * lamp_bri) / 100;
                gg = (lamp_tg * lamp_bri) / 100;
                bb = (lamp_tb * lamp_bri) / 100;
            end
            else
            begin
                h  = lamp_hue % 360;
                v  = (lamp_bri * 255) / 100;
                c  = (v * lamp_sat) / 100;
                hm = h % 120;
                d  = (hm > 60) ? hm - 60 : 60 - hm;
                x  = (c * (60 - d)) / 60;
                m  = v - c;
                // sextant places chroma and the second component
                if (h < 60)       begin rr = c; gg = x; end
                else if (h < 120) begin rr = x; gg = c; end
                else if (h < 180) begin gg = c; bb = x; end
                else if (h < 240) begin gg = x; bb = c; end
                else if (h < 300) begin rr = x; bb = c; end
                else              begin rr = c; bb = x; end
                rr += m;
                gg += m;
                bb += m;
            end
        end
        o.r = COLOR_W'(rr);
        o.g = COLOR_W'(gg);
        o.b = COLOR_W'(bb);
        return o;
    endfunction

    // apply one accepted set event and queue the drive word it causes
    task automatic lamp_apply(input set_word_t w);
        int unsigned t, p;
        case (w.op)
            OP_POWER:      lamp_on = w.val[0];
            OP_BRIGHTNESS: if (w.val != 0) lamp_bri = clip_pct(w.val);
            OP_HUE:
            begin
                lamp_hue       = w.val;
                lamp_temp_mode = 1'b0;
            end
            OP_SATURATION:
            begin
                lamp_sat       = clip_pct(w.val);
                lamp_temp_mode = 1'b0;
            end
            OP_TEMPERATURE:
            begin
                t = w.val;
                if (t < T_MIN) t = T_MIN;
                if (t > T_MAX) t = T_MAX;
                p = t - T_MIN;
                // warm 255/180/80 blended toward cool 180/220/255
                lamp_tr        = COLOR_W'(255 - (75 * p) / TP_MAX);
                lamp_tg        = COLOR_W'(180 + (40 * p) / TP_MAX);
                lamp_tb        = COLOR_W'(80 + (175 * p) / TP_MAX);
                lamp_temp_mode = 1'b1;
            end
            default: ;  // unused opcode leaves the state alone
        endcase
        drive_expected.push_back(lamp_color());
    endtask

    task automatic add_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
        event_words.push_back('{op: op, val: val});
    endtask

    // mostly sensible settings with some full-range noise and unused opcodes
    function automatic set_word_t random_word();
        set_word_t w;
        int        sel;
        sel   = $urandom_range(99);
        w.val = VALUE_W'($urandom);
        if (sel < 8)
        begin
            w.op     = OP_POWER;
            w.val[0] = ($urandom_range(9) != 0);
        end
        else if (sel < 28)
        begin
            w.op = OP_BRIGHTNESS;
            if ($urandom_range(99) < 85) w.val = VALUE_W'($urandom_range(100, 1));
        end
        else if (sel < 52)
        begin
            w.op = OP_HUE;
            if ($urandom_range(99) < 70) w.val = VALUE_W'($urandom_range(719));
        end
        else if (sel < 70)
        begin
            w.op = OP_SATURATION;
            if ($urandom_range(99) < 80) w.val = VALUE_W'($urandom_range(100));
        end
        else if (sel < 92)
        begin
            w.op = OP_TEMPERATURE;
            if ($urandom_range(99) < 75) w.val = VALUE_W'($urandom_range(7000, 1500));
        end
        else
        begin
            w.op = OP_TEMPERATURE + OPCODE_W'($urandom_range(3, 1));
        end
        return w;
    endfunction

    // sender: offers queued event words, idles at random, holds a word until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            opcode    <= '0;
            set_value <= '0;
            lamp_on        = 1'b0;
            lamp_bri       = '0;
            lamp_hue       = '0;
            lamp_sat       = '0;
            lamp_temp_mode = 1'b0;
            lamp_tr        = '0;
            lamp_tg        = '0;
            lamp_tb        = '0;
        end
        else
        begin : send_proc
            set_word_t nxt;
            logic      taken;
            taken = push && !full;
            if (taken)
            begin
                lamp_apply('{op: opcode, val: set_value});
                n_sent <= n_sent + 1;
            end
            // a word that was not taken stays on the ports untouched
            if (!push || taken)
            begin
                if (event_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = event_words.pop_front();
                    push      <= 1'b1;
                    opcode    <= nxt.op;
                    set_value <= nxt.val;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: checks every drive word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin : recv_proc
            rgb_word_t want;
            if (pop && !empty)
            begin
                if (drive_expected.size() == 0)
                begin
                    report_mismatch("drive word with nothing pending", 0, 1);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (red !== want.r)   report_mismatch("red", want.r, red);
                    if (green !== want.g) report_mismatch("green", want.g, green);
                    if (blue !== want.b)  report_mismatch("blue", want.b, blue);
                end
            end
            // one long hold-off so the job queue fills and full backs up the sender
            if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
                $display("light_state_to_rgb_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: dark cases, every opcode, field extremes
        add_word(OP_HUE, 16'd0);              // still off
        add_word(OP_POWER, 16'h0001);         // on, brightness still zero
        add_word(OP_BRIGHTNESS, 16'd0);       // zero brightness is ignored
        add_word(OP_BRIGHTNESS, 16'd100);     // white, saturation zero
        add_word(OP_SATURATION, 16'd100);     // pure red
        add_word(OP_HUE, 16'd60);
        add_word(OP_HUE, 16'd120);
        add_word(OP_HUE, 16'd180);
        add_word(OP_HUE, 16'd240);
        add_word(OP_HUE, 16'd300);
        add_word(OP_HUE, 16'd359);
        add_word(OP_HUE, 16'd360);            // wraps to zero
        add_word(OP_HUE, 16'hFFFF);
        add_word(OP_SATURATION, 16'hFFFF);    // clips at full scale
        add_word(OP_BRIGHTNESS, 16'd1);
        add_word(OP_BRIGHTNESS, 16'hFFFF);
        add_word(OP_TEMPERATURE, 16'd0);      // clamps to warm end
        add_word(OP_TEMPERATURE, 16'hFFFF);   // clamps to cool end
        add_word(OP_TEMPERATURE, 16'd4250);
        add_word(OP_BRIGHTNESS, 16'd0);       // ignored in temperature mode too
        add_word(OP_TEMPERATURE + 3'd1, 16'hFFFF);  // unused opcodes
        add_word(OP_TEMPERATURE + 3'd2, 16'h5A5A);
        add_word(OP_TEMPERATURE + 3'd3, 16'h0000);
        add_word(OP_POWER, 16'hFFFE);         // bit 0 low turns off
        add_word(OP_POWER, 16'hFFFF);
        for (int i = 0; i < RANDOM_WORDS; i++)
            event_words.push_back(random_word());

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything offered, taken and checked
        while (event_words.size() != 0 || push || drive_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_err == 0)
            $display("light_state_to_rgb_tb: PASS");
        else
            $display("light_state_to_rgb_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/lsr_pkg.sv
sv/lsr_front.sv
sv/lsr_queue.sv
sv/lsr_back.sv
sv/light_state_to_rgb.sv
sim/light_state_to_rgb_tb.sv
